>>> rtl/assert_macros.svh
// Assertion macros shared by the draw engine RTL.
// Depends on a clock clk_i and an active-low reset rst_ni in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define CCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition in one cycle leads to another in the next.
`define CCE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/cce_pkg.sv
// Shared types and constants of the character cell draw engine.
// No dependencies; used by every module of the block.
package cce_pkg;

  // Internal coordinate widths: columns up to 255 plus sums, rows up to 63 plus sums.
  localparam int CW = 9;
  localparam int RW = 8;
  // Line decision value width.
  localparam int DW = 20;

  localparam logic [2:0] KIND_PUT   = 3'd0;
  localparam logic [2:0] KIND_FILL  = 3'd1;
  localparam logic [2:0] KIND_FRAME = 3'd2;
  localparam logic [2:0] KIND_LINE  = 3'd3;
  localparam logic [2:0] KIND_READ  = 3'd4;

  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;

  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [5:0] ROWS_RESET = 6'd25;

  localparam logic [7:0] GLYPH_SPACE  = 8'h20;
  localparam logic [7:0] GLYPH_CORNER = 8'h2B;
  localparam logic [7:0] GLYPH_SIDE   = 8'h7C;
  localparam logic [7:0] GLYPH_EDGE   = 8'h2D;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] start_col;
    logic [4:0] start_row;
    logic [7:0] extent_col;
    logic [5:0] extent_row;
    logic [7:0] glyph;
    logic [3:0] fore_color;
    logic [3:0] back_color;
    logic [3:0] decoration;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] cell_glyph;
    logic [3:0] cell_fore;
    logic [3:0] cell_back;
    logic [3:0] cell_decor;
  } rsp_t;

  typedef struct packed {
    logic [3:0] decor;
    logic [3:0] back;
    logic [3:0] fore;
    logic [7:0] glyph;
  } cell_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctrl_t;

endpackage

>>> rtl/character_cell_draw_engine_unit.sv
// Top level of the character cell draw engine: size registers and the
// sequencer around the cell memory. Depends on cce_pkg, cce_seq, cce_cell_mem.
//
// After reset the block sweeps the cell store to spaces, one cell a cycle,
// over all MAX_COLUMNS*MAX_ROWS cells (4096 with the defaults), holding busy
// high meanwhile; size registers may be written during the sweep. A request
// is taken when start is high and busy is low, and its one result appears on
// rsp_o with done_o high for a single cycle; the result cannot be held off.
// Timing is set by the single port of the cell memory, one cell per cycle:
// put, unused kinds, rejected requests and in-bounds zero-size fills or
// frames answer from the idle state, a read waits in ST_READ, fill and
// frame walk the rectangle, a line writes its points. The user makes screen
// size writes while the block is idle; the block does not enforce it.
module character_cell_draw_engine_unit import cce_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  cmd_t       cmd_i,
  output logic       done_o,
  output rsp_t       rsp_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]    cols_q;
  logic [5:0]    rows_q;
  logic [CW-1:0] eff_cols;
  logic [RW-1:0] eff_rows;
  mem_ctrl_t     mem_ctrl;
  logic [AW-1:0] mem_addr;
  cell_t         mem_wdata, mem_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLUMNS: cols_q <= cfg_data_i;
        CFG_ROWS:    rows_q <= cfg_data_i[5:0];
        default:     cols_q <= cols_q;
      endcase
    end
  end

  // saturate the programmed size to the store's dimensions
  assign eff_cols = (CW'(cols_q) > CW'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(cols_q);
  assign eff_rows = (RW'(rows_q) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_q);

  cce_seq #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS),
    .DEPTH       (DEPTH),
    .AW          (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .cmd_i       (cmd_i),
    .eff_cols_i  (eff_cols),
    .eff_rows_i  (eff_rows),
    .mem_ctrl_o  (mem_ctrl),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata),
    .done_o      (done_o),
    .rsp_o       (rsp_o)
  );

  cce_cell_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule

>>> rtl/cce_cell_mem.sv
// Cell store: single-port synchronous memory, one write or one read a cycle.
// Depends on cce_pkg for the cell and control types.
module cce_cell_mem import cce_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic            clk_i,
  input  mem_ctrl_t       ctrl_i,
  input  logic [AW-1:0]   addr_i,
  input  cell_t           wdata_i,
  output cell_t           rdata_o
);

  cell_t mem_q [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/cce_seq.sv
// Command sequencer: clearing pass, bounds checks, rectangle/frame walk,
// line stepping and the result register. Depends on cce_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cce_seq import cce_pkg::*; #(
  parameter int MAX_COLUMNS = 128,
  parameter int MAX_ROWS    = 32,
  parameter int DEPTH       = MAX_COLUMNS * MAX_ROWS,
  parameter int AW          = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  cmd_t          cmd_i,
  input  logic [CW-1:0] eff_cols_i,
  input  logic [RW-1:0] eff_rows_i,
  output mem_ctrl_t     mem_ctrl_o,
  output logic [AW-1:0] mem_addr_o,
  output cell_t         mem_wdata_o,
  input  cell_t         mem_rdata_i,
  output logic          done_o,
  output rsp_t          rsp_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_RECT  = 3'd3;
  localparam logic [2:0] ST_LINE  = 3'd4;

  logic [2:0]           state_q, state_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic                 done_q, done_d;
  rsp_t                 rsp_q, rsp_d;
  cmd_t                 cmd_q, cmd_d;
  logic [CW-1:0]        c_q, c_d, right_q, right_d;
  logic [RW-1:0]        r_q, r_d, bot_q, bot_d;
  logic signed [DW-1:0] d_q, d_d, up_q, up_d, flat_q, flat_d;

  mem_ctrl_t            mem_ctrl;
  logic [CW-1:0]        sc_w, ec_w;
  logic [RW-1:0]        sr_w, er_w;
  logic                 pt_ok, rect_ok;
  logic signed [DW-1:0] dx_w, dy_w;
  logic                 side, topbot, is_fill, line_ok, past_end;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row,
                                            input logic [CW-1:0] col);
    return AW'(int'(row) * MAX_COLUMNS + int'(col));
  endfunction

  assign sc_w = CW'(cmd_i.start_col);
  assign ec_w = CW'(cmd_i.extent_col);
  assign sr_w = RW'(cmd_i.start_row);
  assign er_w = RW'(cmd_i.extent_row);

  assign pt_ok   = (sc_w < eff_cols_i) && (sr_w < eff_rows_i);
  assign rect_ok = ((sc_w + ec_w) <= eff_cols_i) && ((sr_w + er_w) <= eff_rows_i);
  assign dx_w    = DW'(cmd_i.extent_col) - DW'(cmd_i.start_col);
  assign dy_w    = DW'(cmd_i.extent_row) - DW'(cmd_i.start_row);

  assign is_fill  = (cmd_q.kind == KIND_FILL);
  assign side     = (c_q == CW'(cmd_q.start_col)) || (c_q == right_q);
  assign topbot   = (r_q == RW'(cmd_q.start_row)) || (r_q == bot_q);
  assign past_end = c_q > CW'(cmd_q.extent_col);
  assign line_ok  = (c_q < eff_cols_i) && (r_q < eff_rows_i);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    done_d      = 1'b0;
    rsp_d       = rsp_q;
    cmd_d       = cmd_q;
    c_d         = c_q;
    r_d         = r_q;
    right_d     = right_q;
    bot_d       = bot_q;
    d_d         = d_q;
    up_d        = up_q;
    flat_d      = flat_q;
    mem_ctrl    = '0;
    mem_addr_o  = addr_of(r_q, c_q);
    mem_wdata_o = '{decor: cmd_q.decoration, back: cmd_q.back_color,
                    fore: cmd_q.fore_color, glyph: cmd_q.glyph};

    unique case (state_q)
      ST_CLEAR: begin
        mem_ctrl.wr = 1'b1;
        mem_addr_o  = clr_q;
        mem_wdata_o = '{decor: 4'd0, back: 4'd0, fore: 4'd0, glyph: GLYPH_SPACE};
        clr_d       = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_d       = cmd_i;
          mem_addr_o  = addr_of(sr_w, sc_w);
          mem_wdata_o = '{decor: cmd_i.decoration, back: cmd_i.back_color,
                          fore: cmd_i.fore_color, glyph: cmd_i.glyph};
          unique case (cmd_i.kind)
            KIND_PUT: begin
              done_d       = 1'b1;
              rsp_d        = '0;
              rsp_d.status = !pt_ok;
              mem_ctrl.wr  = pt_ok;
            end
            KIND_READ: begin
              if (pt_ok) begin
                mem_ctrl.rd = 1'b1;
                state_d     = ST_READ;
              end else begin
                done_d       = 1'b1;
                rsp_d        = '0;
                rsp_d.status = 1'b1;
              end
            end
            KIND_FILL, KIND_FRAME: begin
              if (!rect_ok) begin
                done_d       = 1'b1;
                rsp_d        = '0;
                rsp_d.status = 1'b1;
              end else if ((ec_w == '0) || (er_w == '0)) begin
                done_d = 1'b1;
                rsp_d  = '0;
              end else begin
                c_d     = sc_w;
                r_d     = sr_w;
                right_d = sc_w + ec_w - CW'(1);
                bot_d   = sr_w + er_w - RW'(1);
                state_d = ST_RECT;
              end
            end
            KIND_LINE: begin
              if (ec_w < sc_w) begin
                done_d = 1'b1;
                rsp_d  = '0;
              end else begin
                c_d     = sc_w;
                r_d     = sr_w;
                d_d     = (dy_w <<< 1) - dx_w;
                up_d    = (dy_w <<< 1) - (dx_w <<< 1);
                flat_d  = dy_w <<< 1;
                state_d = ST_LINE;
              end
            end
            default: begin
              done_d = 1'b1;
              rsp_d  = '0;
            end
          endcase
        end
      end
      ST_READ: begin
        // read data is valid in the cycle after the request
        done_d           = 1'b1;
        rsp_d            = '0;
        rsp_d.cell_glyph = mem_rdata_i.glyph;
        rsp_d.cell_fore  = mem_rdata_i.fore;
        rsp_d.cell_back  = mem_rdata_i.back;
        rsp_d.cell_decor = mem_rdata_i.decor;
        state_d          = ST_IDLE;
      end
      ST_RECT: begin
        // frame leaves interior cells untouched
        mem_ctrl.wr = is_fill || side || topbot;
        if (!is_fill) begin
          if (side) begin
            mem_wdata_o.glyph = topbot ? GLYPH_CORNER : GLYPH_SIDE;
          end else begin
            mem_wdata_o.glyph = GLYPH_EDGE;
          end
        end
        if (c_q == right_q) begin
          c_d = CW'(cmd_q.start_col);
          if (r_q == bot_q) begin
            done_d  = 1'b1;
            rsp_d   = '0;
            state_d = ST_IDLE;
          end else begin
            r_d = r_q + RW'(1);
          end
        end else begin
          c_d = c_q + CW'(1);
        end
      end
      ST_LINE: begin
        if (past_end) begin
          done_d  = 1'b1;
          rsp_d   = '0;
          state_d = ST_IDLE;
        end else if (!line_ok) begin
          // stop at the first point off the screen
          done_d       = 1'b1;
          rsp_d        = '0;
          rsp_d.status = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          mem_ctrl.wr = 1'b1;
          c_d         = c_q + CW'(1);
          if (d_q > 0) begin
            r_d = r_q + RW'(1);
            d_d = d_q + up_q;
          end else begin
            d_d = d_q + flat_q;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q   <= rsp_d;
    cmd_q   <= cmd_d;
    c_q     <= c_d;
    r_q     <= r_d;
    right_q <= right_d;
    bot_q   <= bot_d;
    d_q     <= d_d;
    up_q    <= up_d;
    flat_q  <= flat_d;
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign mem_ctrl_o = mem_ctrl;
  assign done_o     = done_q;
  assign rsp_o      = rsp_q;

  `CCE_ASSERT(a_mem_excl, !(mem_ctrl.wr && mem_ctrl.rd), "memory read and write in one cycle")
  `CCE_ASSERT_NEXT(a_read_wait, mem_ctrl.rd, state_q == ST_READ, "read request without wait")
  `CCE_ASSERT_NEXT(a_read_done, state_q == ST_READ, done_q && (state_q == ST_IDLE), "read lost")

endmodule
